### rtl/pfsc_pkg.sv
// Shared types, codes and coil pattern functions for the paper feed stepper controller.
// No dependencies; imported by the top level and by its checker.
package pfsc_pkg;

    // coil drive code
    typedef logic [1:0] t_drive;
    localparam t_drive DRV_OFF = 2'd0;
    localparam t_drive DRV_FWD = 2'd1;
    localparam t_drive DRV_REV = 2'd2;

    // status reply code
    typedef logic [2:0] t_reply;
    localparam t_reply RPL_OK          = 3'd0;
    localparam t_reply RPL_BAD_PARAM   = 3'd1;
    localparam t_reply RPL_BAD_LEN     = 3'd2;
    localparam t_reply RPL_UNSUPPORTED = 3'd3;
    localparam t_reply RPL_PAPER       = 3'd4;

    // host command bytes
    localparam logic [7:0] CODE_TEST  = 8'h10;
    localparam logic [7:0] CODE_FEED  = 8'h11;
    localparam logic [7:0] LEN_TEST   = 8'd1;
    localparam logic [7:0] LEN_FEED   = 8'd2;
    localparam logic [7:0] PARAM_NONE = 8'h00;
    localparam logic [7:0] PARAM_BAD  = 8'hFF;

    // item kinds
    localparam logic CMD_TIME   = 1'b0;
    localparam logic CMD_PACKET = 1'b1;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TICK_THRESHOLD    = 2'd0;
    localparam t_cfg_idx CFG_HOLD_TICKS        = 2'd1;
    localparam t_cfg_idx CFG_PAPER_ERROR_TICKS = 2'd2;

    // configuration reset values
    localparam logic [7:0]  RST_TICK_THRESHOLD    = 8'd3;
    localparam logic [7:0]  RST_HOLD_TICKS        = 8'd25;
    localparam logic [15:0] RST_PAPER_ERROR_TICKS = 16'd5000;

    // full-step sequence: A+B+, A+B-, A-B-, A-B+
    function automatic t_drive pattern_a(input logic [1:0] phase);
        t_drive drv;
        unique case (phase)
            2'd0, 2'd1: drv = DRV_FWD;
            default:    drv = DRV_REV;
        endcase
        return drv;
    endfunction

    function automatic t_drive pattern_b(input logic [1:0] phase);
        t_drive drv;
        unique case (phase)
            2'd0, 2'd3: drv = DRV_FWD;
            default:    drv = DRV_REV;
        endcase
        return drv;
    endfunction

endpackage

### rtl/paper_feed_stepper_controller.sv
// Paper feed stepper controller: input beat register, single-pass update, result register.
// Depends on pfsc_pkg.
//
// A beat goes from the input register through the update into the result register.
// One beat per cycle while the output drains; time path: 32-bit subtract, 33-bit add, compare.
// The input stage refills while a result waits, as long as the result stage can drain.
// Reset (synchronous, active low) clears all motor state, coils off, config to defaults.
module paper_feed_stepper_controller
    import pfsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [31:0] i_time_now,
    input  logic        i_paper_present,
    input  logic [7:0]  i_cmd_code,
    input  logic [7:0]  i_cmd_param,
    input  logic [7:0]  i_packet_length,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_coil_a,
    output logic [1:0]  o_coil_b,
    output logic        o_reply_valid,
    output logic [2:0]  o_reply_code,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    // configuration
    logic [7:0]  r_tick_threshold;
    logic [7:0]  r_hold_ticks;
    logic [15:0] r_paper_error_ticks;

    // input stage
    logic        r_in_valid;
    logic        r_in_command;
    logic [31:0] r_in_time_now;
    logic        r_in_paper;
    logic [7:0]  r_in_code;
    logic [7:0]  r_in_param;
    logic [7:0]  r_in_len;

    // motor state
    logic [7:0]  r_pending, n_pending;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_hold, n_hold;
    logic [15:0] r_paper_count, n_paper_count;
    logic [31:0] r_last_time, n_last_time;
    logic [7:0]  r_elapsed, n_elapsed;
    t_drive      r_coil_a, n_coil_a;
    t_drive      r_coil_b, n_coil_b;

    // result stage
    logic        r_out_valid;
    t_drive      r_out_coil_a;
    t_drive      r_out_coil_b;
    logic        r_out_reply_valid;
    t_reply      r_out_reply_code;

    logic        n_reply_valid;
    t_reply      n_reply_code;
    logic        out_free;
    logic        do_step;
    logic        in_take;
    logic [31:0] time_diff;
    logic [32:0] elapsed_total;
    logic [16:0] paper_next;

    // handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign do_step    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_threshold    <= RST_TICK_THRESHOLD;
            r_hold_ticks        <= RST_HOLD_TICKS;
            r_paper_error_ticks <= RST_PAPER_ERROR_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TICK_THRESHOLD:    r_tick_threshold    <= i_cfg_wdata[7:0];
                CFG_HOLD_TICKS:        r_hold_ticks        <= i_cfg_wdata[7:0];
                CFG_PAPER_ERROR_TICKS: r_paper_error_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (do_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_command  <= i_command;
            r_in_time_now <= i_time_now;
            r_in_paper    <= i_paper_present;
            r_in_code     <= i_cmd_code;
            r_in_param    <= i_cmd_param;
            r_in_len      <= i_packet_length;
        end
    end

    // elapsed time and paper counter arithmetic
    assign time_diff     = r_in_time_now - r_last_time;
    assign elapsed_total = {1'b0, time_diff} + {25'd0, r_elapsed};
    assign paper_next    = {1'b0, r_paper_count} + 17'd1;

    // next state for one beat
    always_comb begin
        n_pending     = r_pending;
        n_phase       = r_phase;
        n_hold        = r_hold;
        n_paper_count = r_paper_count;
        n_last_time   = r_last_time;
        n_elapsed     = r_elapsed;
        n_coil_a      = r_coil_a;
        n_coil_b      = r_coil_b;
        n_reply_valid = 1'b0;
        n_reply_code  = RPL_OK;
        if (r_in_command == CMD_TIME) begin
            if (r_in_time_now != r_last_time) begin
                n_last_time = r_in_time_now;
                if (elapsed_total > {25'd0, r_tick_threshold}) begin
                    // motor tick
                    n_elapsed = '0;
                    if (r_in_paper) begin
                        priority if (r_pending != '0) begin
                            n_hold    = r_hold_ticks;
                            n_pending = r_pending - 8'd1;
                            n_coil_a  = pattern_a(r_phase);
                            n_coil_b  = pattern_b(r_phase);
                            n_phase   = r_phase + 2'd1;
                        end else if (r_hold != '0) begin
                            n_hold = r_hold - 8'd1;
                        end else begin
                            n_coil_a = DRV_OFF;
                            n_coil_b = DRV_OFF;
                        end
                        n_paper_count = r_paper_error_ticks;
                    end else if (paper_next >= {1'b0, r_paper_error_ticks}) begin
                        // repeated missing paper: error, drop steps, release
                        n_paper_count = '0;
                        n_pending     = '0;
                        n_coil_a      = DRV_OFF;
                        n_coil_b      = DRV_OFF;
                        n_reply_valid = 1'b1;
                        n_reply_code  = RPL_PAPER;
                    end else begin
                        n_paper_count = paper_next[15:0];
                    end
                end else begin
                    // sum is at most the threshold here, so it fits
                    n_elapsed = elapsed_total[7:0];
                end
            end
        end else begin
            // host packet
            priority if (r_in_code == CODE_TEST) begin
                if (r_in_len != LEN_TEST) begin
                    n_reply_valid = 1'b1;
                    n_reply_code  = RPL_BAD_LEN;
                end
            end else if (r_in_code == CODE_FEED) begin
                n_reply_valid = 1'b1;
                priority if (r_in_len != LEN_FEED) begin
                    n_reply_code = RPL_BAD_LEN;
                end else if (r_in_param == PARAM_NONE || r_in_param == PARAM_BAD) begin
                    n_reply_code = RPL_BAD_PARAM;
                end else begin
                    n_pending    = r_pending + r_in_param;
                    n_reply_code = RPL_OK;
                end
            end else begin
                n_reply_valid = 1'b1;
                n_reply_code  = RPL_UNSUPPORTED;
            end
        end
    end

    // motor state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending     <= '0;
            r_phase       <= '0;
            r_hold        <= '0;
            r_paper_count <= '0;
            r_last_time   <= '0;
            r_elapsed     <= '0;
            r_coil_a      <= DRV_OFF;
            r_coil_b      <= DRV_OFF;
        end else if (do_step) begin
            r_pending     <= n_pending;
            r_phase       <= n_phase;
            r_hold        <= n_hold;
            r_paper_count <= n_paper_count;
            r_last_time   <= n_last_time;
            r_elapsed     <= n_elapsed;
            r_coil_a      <= n_coil_a;
            r_coil_b      <= n_coil_b;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_out_coil_a      <= n_coil_a;
            r_out_coil_b      <= n_coil_b;
            r_out_reply_valid <= n_reply_valid;
            r_out_reply_code  <= n_reply_code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_coil_a      = r_out_coil_a;
    assign o_coil_b      = r_out_coil_b;
    assign o_reply_valid = r_out_reply_valid;
    assign o_reply_code  = r_out_reply_code;

endmodule

### rtl/pfsc_checker.sv
// Port-level checker for the paper feed stepper controller, with its bind.
// Depends on pfsc_pkg.
module pfsc_checker
    import pfsc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_coil_a,
    input logic [1:0] o_coil_b,
    input logic       o_reply_valid,
    input logic [2:0] o_reply_code
);

    // a beat without a reply carries a zero code
    a_no_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reply_valid) |-> (o_reply_code == RPL_OK))
        else $error("reply code set without a reply");

    // coils are energized together or released together
    a_coils_paired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_coil_a == DRV_OFF) == (o_coil_b == DRV_OFF)))
        else $error("one coil released while the other is driven");

    // a coil never shows the unused drive code
    a_coil_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_coil_a == DRV_OFF || o_coil_a == DRV_FWD || o_coil_a == DRV_REV)
                      && (o_coil_b == DRV_OFF || o_coil_b == DRV_FWD || o_coil_b == DRV_REV)))
        else $error("illegal coil drive code");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_coil_a) && $stable(o_coil_b)
             && $stable(o_reply_valid) && $stable(o_reply_code)))
        else $error("stalled result beat changed");

endmodule

bind paper_feed_stepper_controller pfsc_checker u_pfsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_coil_a      (o_coil_a),
    .o_coil_b      (o_coil_b),
    .o_reply_valid (o_reply_valid),
    .o_reply_code  (o_reply_code)
);
